FILE: sv/dcc_packet_waveform_generator_core_macros.svh
// Assertion macros shared by the checker of the DCC packet waveform generator.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef DCC_PACKET_WAVEFORM_GENERATOR_CORE_MACROS_SVH
`define DCC_PACKET_WAVEFORM_GENERATOR_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition at one edge that forces a property at the next edge.
`define DCC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/dcc_pwg_pkg.sv
// Shared constants, codes and types of the DCC packet waveform generator.
// Depends on nothing; used by the decoder, the engine, the top level and the testbench.
`default_nettype none

package dcc_pwg_pkg;

    localparam int PREAMBLE_BITS = 12;
    localparam int TIMER_BITS    = 12;
    localparam int FRAME_LEN     = PREAMBLE_BITS + 28;
    localparam int BIT_IDX_W     = $clog2(FRAME_LEN);
    localparam int CFG_W         = 12;
    localparam int LEN_W         = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [2:0] CMD_FORWARD  = 3'd0;
    localparam logic [2:0] CMD_BACKWARD = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_IDLE     = 3'd3;
    localparam logic [2:0] CMD_FUNCTION = 3'd4;

    localparam logic [1:0] REG_LOCO_ADDRESS     = 2'd0;
    localparam logic [1:0] REG_ONE_HALF_TICKS   = 2'd1;
    localparam logic [1:0] REG_ZERO_HALF_TICKS  = 2'd2;
    localparam logic [1:0] REG_TURNOUT_REVERSED = 2'd3;

    localparam logic [7:0]  RST_LOCO_ADDRESS    = 8'd3;
    localparam logic [11:0] RST_ONE_HALF_TICKS  = 12'd58;
    localparam logic [11:0] RST_ZERO_HALF_TICKS = 12'd100;

    localparam logic [7:0] DATA_FORWARD   = 8'h63;
    localparam logic [7:0] DATA_BACKWARD  = 8'h43;
    localparam logic [7:0] DATA_STOP      = 8'h60;
    localparam logic [7:0] IDLE_ADDRESS   = 8'hFF;
    localparam logic [7:0] IDLE_DATA      = 8'h00;
    localparam logic [7:0] FUNC_LOW_BASE  = 8'h80;
    localparam logic [7:0] FUNC_HIGH_BASE = 8'hB0;
    localparam logic [3:0] FUNC_HIGH_FIRST = 4'd5;
    localparam logic [3:0] FUNC_INDEX_MAX  = 4'd8;

    typedef struct packed {
        logic                 ok;
        logic [FRAME_LEN-1:0] frame;
    } cmd_dec_t;

    typedef struct packed {
        logic level_a;
        logic level_b;
        logic sending;
        logic rejected;
    } step_res_t;

endpackage

`default_nettype wire

FILE: sv/dcc_pwg_cmd_decode.sv
// Command decoder: turns a command beat into a packet frame and a validity flag.
// Depends on dcc_pwg_pkg.
`default_nettype none

module dcc_pwg_cmd_decode (
    input  wire logic [2:0]          command_kind,
    input  wire logic [3:0]          function_index,
    input  wire logic [7:0]          loco_address,
    output dcc_pwg_pkg::cmd_dec_t    dec
);

    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] chk;
    logic       ok;

    always_comb
    begin
        ok   = 1'b1;
        addr = loco_address;
        data = dcc_pwg_pkg::IDLE_DATA;
        unique case (command_kind)
            dcc_pwg_pkg::CMD_FORWARD:
            begin
                data = dcc_pwg_pkg::DATA_FORWARD;
            end
            dcc_pwg_pkg::CMD_BACKWARD:
            begin
                data = dcc_pwg_pkg::DATA_BACKWARD;
            end
            dcc_pwg_pkg::CMD_STOP:
            begin
                data = dcc_pwg_pkg::DATA_STOP;
            end
            dcc_pwg_pkg::CMD_IDLE:
            begin
                addr = dcc_pwg_pkg::IDLE_ADDRESS;
                data = dcc_pwg_pkg::IDLE_DATA;
            end
            dcc_pwg_pkg::CMD_FUNCTION:
            begin
                if (function_index > dcc_pwg_pkg::FUNC_INDEX_MAX)
                begin
                    ok = 1'b0;
                end
                else if (function_index >= dcc_pwg_pkg::FUNC_HIGH_FIRST)
                begin
                    data = dcc_pwg_pkg::FUNC_HIGH_BASE
                         | (8'd1 << (function_index - dcc_pwg_pkg::FUNC_HIGH_FIRST));
                end
                else
                begin
                    data = dcc_pwg_pkg::FUNC_LOW_BASE | (8'd1 << function_index);
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign chk = addr ^ data;

    assign dec.ok    = ok;
    assign dec.frame = {{dcc_pwg_pkg::PREAMBLE_BITS{1'b1}}, 1'b0, addr, 1'b0, data,
                        1'b0, chk, 1'b1};

endmodule

`default_nettype wire

FILE: sv/dcc_pwg_engine.sv
// Packet send engine: frame, bit position, half-period timer and track levels.
// Depends on dcc_pwg_pkg; fed by dcc_pwg_cmd_decode.
`default_nettype none

module dcc_pwg_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  op,
    input  wire dcc_pwg_pkg::cmd_dec_t dec,
    input  wire logic [7:0]            repeat_count,
    input  wire logic [11:0]           one_half_ticks,
    input  wire logic [11:0]           zero_half_ticks,
    output dcc_pwg_pkg::step_res_t     res
);

    logic [dcc_pwg_pkg::FRAME_LEN-1:0]  frame_shift_reg, frame_shift_next;
    logic [dcc_pwg_pkg::BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic                               second_half_reg, second_half_next;
    logic [dcc_pwg_pkg::TIMER_BITS-1:0] half_timer_reg, half_timer_next;
    logic [7:0]                         repeats_left_reg, repeats_left_next;
    logic                               level_a_reg, level_a_next;
    logic                               level_b_reg, level_b_next;
    logic                               sending_reg, sending_next;
    logic                               rejected;

    logic                               cur_bit;
    logic [dcc_pwg_pkg::LEN_W-1:0]      len_raw;
    logic [dcc_pwg_pkg::LEN_W-1:0]      len_clamp;
    logic [dcc_pwg_pkg::TIMER_BITS-1:0] half_len;
    logic [dcc_pwg_pkg::TIMER_BITS-1:0] timer_inc;

    assign cur_bit = frame_shift_reg[dcc_pwg_pkg::BIT_IDX_W'(dcc_pwg_pkg::FRAME_LEN - 1)
                                     - bit_index_reg];

    always_comb
    begin
        len_raw = cur_bit ? dcc_pwg_pkg::LEN_W'(one_half_ticks)
                          : dcc_pwg_pkg::LEN_W'(zero_half_ticks);
        if (len_raw == '0)
        begin
            len_clamp = dcc_pwg_pkg::LEN_W'(1);
        end
        else if (len_raw > dcc_pwg_pkg::LEN_W'(dcc_pwg_pkg::TIMER_MAX))
        begin
            len_clamp = dcc_pwg_pkg::LEN_W'(dcc_pwg_pkg::TIMER_MAX);
        end
        else
        begin
            len_clamp = len_raw;
        end
    end

    assign half_len  = len_clamp[dcc_pwg_pkg::TIMER_BITS-1:0];
    assign timer_inc = half_timer_reg + dcc_pwg_pkg::TIMER_BITS'(1);

    always_comb
    begin
        frame_shift_next  = frame_shift_reg;
        bit_index_next    = bit_index_reg;
        second_half_next  = second_half_reg;
        half_timer_next   = half_timer_reg;
        repeats_left_next = repeats_left_reg;
        level_a_next      = level_a_reg;
        level_b_next      = level_b_reg;
        sending_next      = sending_reg;
        rejected          = 1'b0;
        if (op == dcc_pwg_pkg::OP_LOAD)
        begin
            if (sending_reg || !dec.ok)
            begin
                rejected = 1'b1;
            end
            else if (repeat_count != 8'd0)
            begin
                frame_shift_next  = dec.frame;
                bit_index_next    = '0;
                repeats_left_next = repeat_count;
                sending_next      = 1'b1;
                second_half_next  = 1'b0;
                half_timer_next   = '0;
                level_a_next      = 1'b0;
                level_b_next      = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            if (timer_inc < half_len)
            begin
                half_timer_next = timer_inc;
            end
            else
            begin
                half_timer_next = '0;
                if (!second_half_reg)
                begin
                    second_half_next = 1'b1;
                    level_a_next     = 1'b1;
                    level_b_next     = 1'b0;
                end
                else if (bit_index_reg == dcc_pwg_pkg::BIT_IDX_W'(dcc_pwg_pkg::FRAME_LEN - 1))
                begin
                    bit_index_next    = '0;
                    repeats_left_next = repeats_left_reg - 8'd1;
                    if (repeats_left_reg == 8'd1)
                    begin
                        sending_next     = 1'b0;
                        second_half_next = 1'b0;
                    end
                    else
                    begin
                        second_half_next = 1'b0;
                        level_a_next     = 1'b0;
                        level_b_next     = 1'b1;
                    end
                end
                else
                begin
                    bit_index_next   = bit_index_reg + dcc_pwg_pkg::BIT_IDX_W'(1);
                    second_half_next = 1'b0;
                    level_a_next     = 1'b0;
                    level_b_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg  <= '0;
            bit_index_reg    <= '0;
            second_half_reg  <= 1'b0;
            half_timer_reg   <= '0;
            repeats_left_reg <= '0;
            level_a_reg      <= 1'b0;
            level_b_reg      <= 1'b0;
            sending_reg      <= 1'b0;
        end
        else if (step)
        begin
            frame_shift_reg  <= frame_shift_next;
            bit_index_reg    <= bit_index_next;
            second_half_reg  <= second_half_next;
            half_timer_reg   <= half_timer_next;
            repeats_left_reg <= repeats_left_next;
            level_a_reg      <= level_a_next;
            level_b_reg      <= level_b_next;
            sending_reg      <= sending_next;
        end
    end

    assign res.level_a  = level_a_next;
    assign res.level_b  = level_b_next;
    assign res.sending  = sending_next;
    assign res.rejected = rejected;

endmodule

`default_nettype wire

FILE: sv/dcc_packet_waveform_generator_core.sv
// Top level of the DCC packet waveform generator: input register, configuration
// registers, result register. Depends on dcc_pwg_pkg, dcc_pwg_cmd_decode, dcc_pwg_engine.
//
// Each input beat is either one time tick or a command that loads a baseline track
// packet, and each gives exactly one result beat with the track and turnout levels,
// the busy flag and the reject flag. The block takes one beat every clock cycle while
// the result side is not stalled. A beat is captured in the input register, and its
// result is written to the result register as the beat leaves the input register;
// the packet state updates in that same cycle, which sets that rate. A stalled result
// holds the input register, and the input side backs up only when both registers are
// full. Configuration writes take effect at once and should be made while no beat is
// in flight.
`default_nettype none

module dcc_packet_waveform_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [2:0]  command_kind,
    input  wire logic [3:0]  function_index,
    input  wire logic [7:0]  repeat_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             track_a,
    output logic             track_b,
    output logic             turnout_a,
    output logic             turnout_b,
    output logic             busy_res,
    output logic             rejected,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    logic        in_valid_reg;
    logic        op_reg;
    logic [2:0]  command_kind_reg;
    logic [3:0]  function_index_reg;
    logic [7:0]  repeat_count_reg;

    logic [7:0]  loco_address_reg;
    logic [11:0] one_half_ticks_reg;
    logic [11:0] zero_half_ticks_reg;
    logic        turnout_reversed_reg;

    logic        out_valid_reg;
    logic        track_a_reg;
    logic        track_b_reg;
    logic        turnout_a_reg;
    logic        turnout_b_reg;
    logic        busy_reg;
    logic        rejected_reg;

    logic                    step;
    dcc_pwg_pkg::cmd_dec_t   dec;
    dcc_pwg_pkg::step_res_t  res;

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg             <= op;
            command_kind_reg   <= command_kind;
            function_index_reg <= function_index;
            repeat_count_reg   <= repeat_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_address_reg     <= dcc_pwg_pkg::RST_LOCO_ADDRESS;
            one_half_ticks_reg   <= dcc_pwg_pkg::RST_ONE_HALF_TICKS;
            zero_half_ticks_reg  <= dcc_pwg_pkg::RST_ZERO_HALF_TICKS;
            turnout_reversed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcc_pwg_pkg::REG_LOCO_ADDRESS:
                begin
                    loco_address_reg <= cfg_data[7:0];
                end
                dcc_pwg_pkg::REG_ONE_HALF_TICKS:
                begin
                    one_half_ticks_reg <= cfg_data;
                end
                dcc_pwg_pkg::REG_ZERO_HALF_TICKS:
                begin
                    zero_half_ticks_reg <= cfg_data;
                end
                dcc_pwg_pkg::REG_TURNOUT_REVERSED:
                begin
                    turnout_reversed_reg <= cfg_data[0];
                end
            endcase
        end
    end

    dcc_pwg_cmd_decode u_decode (
        .command_kind   (command_kind_reg),
        .function_index (function_index_reg),
        .loco_address   (loco_address_reg),
        .dec            (dec)
    );

    dcc_pwg_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .op              (op_reg),
        .dec             (dec),
        .repeat_count    (repeat_count_reg),
        .one_half_ticks  (one_half_ticks_reg),
        .zero_half_ticks (zero_half_ticks_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            track_a_reg   <= res.level_a;
            track_b_reg   <= res.level_b;
            turnout_a_reg <= turnout_reversed_reg ? res.level_b : res.level_a;
            turnout_b_reg <= turnout_reversed_reg ? res.level_a : res.level_b;
            busy_reg      <= res.sending;
            rejected_reg  <= res.rejected;
        end
    end

    assign out_valid = out_valid_reg;
    assign track_a   = track_a_reg;
    assign track_b   = track_b_reg;
    assign turnout_a = turnout_a_reg;
    assign turnout_b = turnout_b_reg;
    assign busy_res  = busy_reg;
    assign rejected  = rejected_reg;

endmodule

`default_nettype wire

FILE: sv/dcc_pwg_checker.sv
// Port-level checker for the DCC packet waveform generator, bound to the top level.
// Depends on dcc_packet_waveform_generator_core_macros.svh.
`include "dcc_packet_waveform_generator_core_macros.svh"
`default_nettype none

module dcc_pwg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        track_a,
    input wire logic        track_b,
    input wire logic        turnout_a,
    input wire logic        turnout_b,
    input wire logic        busy_res,
    input wire logic        rejected
);

    `DCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(track_a) && $stable(busy_res) && $stable(rejected),
        "Stalled result beat changed or dropped.")

    `DCC_ASSERT(a_track_complement, !(out_valid && busy_res) || (track_a != track_b),
        "Track outputs not complementary while sending.")

    `DCC_ASSERT(a_turnout_follows, !out_valid
        || (turnout_a == track_a && turnout_b == track_b)
        || (turnout_a == track_b && turnout_b == track_a),
        "Turnout outputs follow neither track mapping.")

    `DCC_ASSERT(a_idle_track_b_low, !(out_valid && !busy_res) || !track_b,
        "Second track output high while not sending.")

endmodule

bind dcc_packet_waveform_generator_core dcc_pwg_checker u_dcc_pwg_checker (.*);

`default_nettype wire

FILE: test/dcc_packet_waveform_generator_core_tb.sv
// Self-checking testbench for dcc_packet_waveform_generator_core: directed beats, then random
// command and tick streams under several register settings, checked vs typed or predicted levels.
// Depends on dcc_pwg_pkg and the block's RTL.
module dcc_packet_waveform_generator_core_tb;

    localparam int CYCLE_LIMIT        = 2_000_000;
    localparam int RANDOM_PHASE_BEATS = 120;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int DIRECTED_ROWS      = 25;

    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    typedef struct packed {
        logic track_a;
        logic track_b;
        logic turnout_a;
        logic turnout_b;
        logic busy;
        logic rejected;
    } line_levels_t;

    typedef struct packed {
        logic         op;
        logic [2:0]   kind;
        logic [3:0]   fidx;
        logic [7:0]   reps;
        logic         typed;
        line_levels_t want;
    } stim_row_t;

    localparam line_levels_t LV_QUIET  = '0;
    localparam line_levels_t LV_REJECT = '{rejected: 1'b1, default: 1'b0};
    localparam line_levels_t LV_START  =
        '{track_b: 1'b1, turnout_b: 1'b1, busy: 1'b1, default: 1'b0};
    localparam line_levels_t LV_START_REJECT =
        '{track_b: 1'b1, turnout_b: 1'b1, busy: 1'b1, rejected: 1'b1, default: 1'b0};

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic        op             = 1'b0;
    logic [2:0]  command_kind   = '0;
    logic [3:0]  function_index = '0;
    logic [7:0]  repeat_count   = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        track_a;
    logic        track_b;
    logic        turnout_a;
    logic        turnout_b;
    logic        busy_res;
    logic        rejected;
    logic        cfg_we         = 1'b0;
    logic [1:0]  cfg_index      = '0;
    logic [11:0] cfg_data       = '0;

    logic [7:0]  shadow_address   = dcc_pwg_pkg::RST_LOCO_ADDRESS;
    logic [11:0] shadow_one_half  = dcc_pwg_pkg::RST_ONE_HALF_TICKS;
    logic [11:0] shadow_zero_half = dcc_pwg_pkg::RST_ZERO_HALF_TICKS;
    logic        shadow_reversed  = 1'b0;

    logic [dcc_pwg_pkg::FRAME_LEN-1:0]  pkt_frame        = '0;
    int                                 pkt_bit_pos      = 0;
    logic                               pkt_second_half  = 1'b0;
    logic [dcc_pwg_pkg::TIMER_BITS-1:0] pkt_half_timer   = '0;
    logic [7:0]                         pkt_repeats_left = '0;
    logic                               pkt_level_a      = 1'b0;
    logic                               pkt_level_b      = 1'b0;
    logic                               pkt_sending      = 1'b0;

    line_levels_t levels_due[$];
    stim_row_t    directed_rows [DIRECTED_ROWS];

    int  burst_left           = 0;
    int  cycle_count          = 0;
    int  fault_count          = 0;
    int  beats_sent           = 0;
    int  commands_sent        = 0;
    int  commands_rejected    = 0;
    int  packets_started      = 0;
    int  results_checked      = 0;
    int  stalled_input_cycles = 0;
    int  settings_applied     = 0;
    bit  hold_requested       = 1'b0;
    bit  hold_done            = 1'b0;

    dcc_packet_waveform_generator_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .command_kind   (command_kind),
        .function_index (function_index),
        .repeat_count   (repeat_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .track_a        (track_a),
        .track_b        (track_b),
        .turnout_a      (turnout_a),
        .turnout_b      (turnout_b),
        .busy_res       (busy_res),
        .rejected       (rejected),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic start_bit_low();
        begin
            pkt_second_half = 1'b0;
            pkt_half_timer  = '0;
            pkt_level_a     = 1'b0;
            pkt_level_b     = 1'b1;
        end
    endtask

    task automatic predict_line_levels(input logic o, input logic [2:0] k, input logic [3:0] fi,
                                       input logic [7:0] rc, output line_levels_t lv);
        logic [7:0]  addr;
        logic [7:0]  data;
        logic        ok;
        logic [11:0] half_len;
        begin
            lv.rejected = 1'b0;
            if (o == dcc_pwg_pkg::OP_LOAD)
            begin
                addr = shadow_address;
                data = dcc_pwg_pkg::IDLE_DATA;
                ok   = !pkt_sending;
                unique case (k)
                    dcc_pwg_pkg::CMD_FORWARD:  data = dcc_pwg_pkg::DATA_FORWARD;
                    dcc_pwg_pkg::CMD_BACKWARD: data = dcc_pwg_pkg::DATA_BACKWARD;
                    dcc_pwg_pkg::CMD_STOP:     data = dcc_pwg_pkg::DATA_STOP;
                    dcc_pwg_pkg::CMD_IDLE:
                    begin
                        addr = dcc_pwg_pkg::IDLE_ADDRESS;
                        data = dcc_pwg_pkg::IDLE_DATA;
                    end
                    dcc_pwg_pkg::CMD_FUNCTION:
                    begin
                        if (fi > dcc_pwg_pkg::FUNC_INDEX_MAX)
                            ok = 1'b0;
                        else if (fi >= dcc_pwg_pkg::FUNC_HIGH_FIRST)
                            data = dcc_pwg_pkg::FUNC_HIGH_BASE
                                 | (8'd1 << (fi - dcc_pwg_pkg::FUNC_HIGH_FIRST));
                        else
                            data = dcc_pwg_pkg::FUNC_LOW_BASE | (8'd1 << fi);
                    end
                    default: ok = 1'b0;
                endcase
                if (!ok)
                begin
                    lv.rejected = 1'b1;
                end
                else if (rc != 8'd0)
                begin
                    pkt_frame = {{dcc_pwg_pkg::PREAMBLE_BITS{1'b1}}, 1'b0, addr, 1'b0, data,
                                 1'b0, addr ^ data, 1'b1};
                    pkt_bit_pos      = 0;
                    pkt_repeats_left = rc;
                    pkt_sending      = 1'b1;
                    start_bit_low();
                end
            end
            else if (pkt_sending)
            begin
                half_len = pkt_frame[dcc_pwg_pkg::FRAME_LEN - 1 - pkt_bit_pos]
                         ? shadow_one_half : shadow_zero_half;
                if (half_len == 12'd0)
                    half_len = 12'd1;
                pkt_half_timer = pkt_half_timer + 1'b1;
                if (pkt_half_timer >= half_len)
                begin
                    pkt_half_timer = '0;
                    if (!pkt_second_half)
                    begin
                        pkt_second_half = 1'b1;
                        pkt_level_a     = 1'b1;
                        pkt_level_b     = 1'b0;
                    end
                    else
                    begin
                        pkt_bit_pos++;
                        if (pkt_bit_pos >= dcc_pwg_pkg::FRAME_LEN)
                        begin
                            pkt_bit_pos      = 0;
                            pkt_repeats_left = pkt_repeats_left - 8'd1;
                            if (pkt_repeats_left == 8'd0)
                            begin
                                pkt_sending     = 1'b0;
                                pkt_second_half = 1'b0;
                            end
                        end
                        if (pkt_sending)
                            start_bit_low();
                    end
                end
            end
            lv.track_a   = pkt_level_a;
            lv.track_b   = pkt_level_b;
            lv.turnout_a = shadow_reversed ? pkt_level_b : pkt_level_a;
            lv.turnout_b = shadow_reversed ? pkt_level_a : pkt_level_b;
            lv.busy      = pkt_sending;
        end
    endtask

    task automatic send_beat(input logic o, input logic [2:0] k, input logic [3:0] fi,
                             input logic [7:0] rc, input logic use_typed,
                             input line_levels_t typed_levels);
        int           gap;
        line_levels_t predicted;
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid       <= 1'b1;
            op             <= o;
            command_kind   <= k;
            function_index <= fi;
            repeat_count   <= rc;
            do @(posedge clk); while (!in_ready);
            predict_line_levels(o, k, fi, rc, predicted);
            levels_due.push_back(use_typed ? typed_levels : predicted);
            beats_sent++;
            if (o == dcc_pwg_pkg::OP_LOAD)
            begin
                commands_sent++;
                if (predicted.rejected)
                    commands_rejected++;
                else if (rc != 8'd0)
                    packets_started++;
            end
        end
    endtask

    task automatic drain_packet();
        begin
            while (pkt_sending)
                send_beat(dcc_pwg_pkg::OP_TICK, 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'b0, LV_QUIET);
            in_valid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic run_random_phase(input int beats);
        int         count;
        int         roll;
        logic       o;
        logic [2:0] k;
        logic [3:0] fi;
        logic [7:0] rc;
        begin
            count = 0;
            while (count < beats)
            begin
                roll = $urandom_range(0, 9);
                o    = dcc_pwg_pkg::OP_TICK;
                k    = 3'($urandom_range(0, 7));
                fi   = 4'($urandom_range(0, 15));
                rc   = 8'($urandom_range(0, 255));
                if (!pkt_sending && roll < 7)
                begin
                    o = dcc_pwg_pkg::OP_LOAD;
                    k = 3'($urandom_range(0, 4));
                    if (k == dcc_pwg_pkg::CMD_FUNCTION)
                        fi = 4'($urandom_range(0, 8));
                    rc = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 2));
                end
                else if (roll == 9)
                begin
                    o = dcc_pwg_pkg::OP_LOAD;
                    if (!pkt_sending && (k < dcc_pwg_pkg::CMD_FUNCTION ||
                                         (k == dcc_pwg_pkg::CMD_FUNCTION &&
                                          fi <= dcc_pwg_pkg::FUNC_INDEX_MAX)))
                        rc = rc & 8'h03;
                end
                send_beat(o, k, fi, rc, 1'b0, LV_QUIET);
                count++;
            end
            drain_packet();
        end
    endtask

    task automatic apply_settings(input logic [11:0] addr_v, input logic [11:0] one_v,
                                  input logic [11:0] zero_v, input logic [11:0] rev_v);
        logic [1:0]  reg_ids [4];
        logic [11:0] reg_vals [4];
        begin
            reg_ids  = '{dcc_pwg_pkg::REG_LOCO_ADDRESS, dcc_pwg_pkg::REG_ONE_HALF_TICKS,
                         dcc_pwg_pkg::REG_ZERO_HALF_TICKS, dcc_pwg_pkg::REG_TURNOUT_REVERSED};
            reg_vals = '{addr_v, one_v, zero_v, rev_v};
            while (levels_due.size() != 0) @(posedge clk);
            repeat (3) @(posedge clk);
            for (int r = 0; r < 4; r++)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= reg_ids[r];
                cfg_data  <= reg_vals[r];
                @(posedge clk);
            end
            cfg_we <= 1'b0;
            shadow_address   = addr_v[7:0];
            shadow_one_half  = one_v;
            shadow_zero_half = zero_v;
            shadow_reversed  = rev_v[0];
            settings_applied++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        line_levels_t got;
        line_levels_t want;
        if (in_valid && !in_ready)
            stalled_input_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{track_a, track_b, turnout_a, turnout_b, busy_res, rejected};
            if (levels_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Result beat with nothing expected at cycle %0d", cycle_count);
            end
            else
            begin
                want = levels_due.pop_front();
                results_checked++;
                if (got.track_a !== want.track_a || got.track_b !== want.track_b ||
                    got.turnout_a !== want.turnout_a || got.turnout_b !== want.turnout_b ||
                    got.busy !== want.busy || got.rejected !== want.rejected)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"Mismatch at cycle %0d: expected a=%b b=%b ta=%b tb=%b ",
                                  "busy=%b rej=%b, got a=%b b=%b ta=%b tb=%b busy=%b rej=%b"},
                                 cycle_count, want.track_a, want.track_b, want.turnout_a,
                                 want.turnout_b, want.busy, want.rejected, got.track_a,
                                 got.track_b, got.turnout_a, got.turnout_b, got.busy,
                                 got.rejected);
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int window;
        int beat_phase;
        mode       = 0;
        window     = 0;
        beat_phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requested && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (window == 0)
                begin
                    mode   = $urandom_range(0, 3);
                    window = $urandom_range(20, 120);
                end
                window--;
                beat_phase++;
                unique case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= (beat_phase % 4) != 0;
                    2:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (beat_phase % 5) == 0;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, levels_due.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        directed_rows = '{
            '{dcc_pwg_pkg::OP_TICK, dcc_pwg_pkg::CMD_FORWARD,  4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd9,  8'd1,   1'b1, LV_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd15, 8'd255, 1'b1, LV_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, KIND_SPARE_A,              4'd0,  8'd1,   1'b1, LV_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, KIND_SPARE_B,              4'd8,  8'd128, 1'b1, LV_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, KIND_SPARE_C,              4'd7,  8'd7,   1'b1, LV_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FORWARD,  4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_BACKWARD, 4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_STOP,     4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_IDLE,     4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd0,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd1,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd2,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd3,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd4,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd5,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd6,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd7,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd8,  8'd0,   1'b1, LV_QUIET},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FORWARD,  4'd0,  8'd1,   1'b1, LV_START},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_STOP,     4'd0,  8'd255, 1'b1,
              LV_START_REJECT},
            '{dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_FUNCTION, 4'd15, 8'd1,   1'b1,
              LV_START_REJECT},
            '{dcc_pwg_pkg::OP_TICK, dcc_pwg_pkg::CMD_FORWARD,  4'd0,  8'd0,   1'b0, LV_QUIET},
            '{dcc_pwg_pkg::OP_TICK, KIND_SPARE_C,              4'd15, 8'd255, 1'b0, LV_QUIET},
            '{dcc_pwg_pkg::OP_TICK, dcc_pwg_pkg::CMD_IDLE,     4'd5,  8'd3,   1'b0, LV_QUIET}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_beat(directed_rows[r].op, directed_rows[r].kind, directed_rows[r].fidx,
                      directed_rows[r].reps, directed_rows[r].typed, directed_rows[r].want);
        in_valid   <= 1'b0;
        burst_left = 0;

        // Shorten the half periods mid-packet so the directed packet finishes quickly.
        apply_settings({4'hA, 8'($urandom_range(0, 255))}, 12'd1, 12'd2, 12'hFFE);
        drain_packet();
        hold_requested = 1'b1;
        run_random_phase(RANDOM_PHASE_BEATS);

        apply_settings(12'h000, 12'd0, 12'd0, 12'h001);
        run_random_phase(RANDOM_PHASE_BEATS);

        apply_settings(12'hFFF, 12'd3, 12'd1, 12'hFFF);
        run_random_phase(RANDOM_PHASE_BEATS);

        apply_settings(12'h0FF, 12'd2, 12'd1, 12'h000);
        send_beat(dcc_pwg_pkg::OP_LOAD, dcc_pwg_pkg::CMD_IDLE, 4'd0, 8'd1, 1'b0, LV_QUIET);
        drain_packet();

        for (int p = 0; p < 2; p++)
        begin
            apply_settings(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 4)),
                           12'($urandom_range(1, 4)), 12'($urandom_range(0, 4095)));
            run_random_phase(RANDOM_PHASE_BEATS);
        end

        while (levels_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d input beats: %0d commands, %0d packets started, %0d refused.",
                 beats_sent, commands_sent, packets_started, commands_rejected);
        $display("Checked %0d result beats across %0d register settings; input stalled %0d cycles.",
                 results_checked, settings_applied, stalled_input_cycles);
        if (fault_count == 0 && levels_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/dcc_pwg_pkg.sv
sv/dcc_pwg_cmd_decode.sv
sv/dcc_pwg_engine.sv
sv/dcc_packet_waveform_generator_core.sv
sv/dcc_pwg_checker.sv
test/dcc_packet_waveform_generator_core_tb.sv
